// ===== src/tgfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Terrain grid culler package
// Shared widths, register indexes and the types that travel between the
// modules of the terrain grid frustum culler.
// ----------------------------------------------------------------------------
package tgfc_pkg;

    // Payload widths.
    localparam int COORD_W     = 16;
    localparam int IDX_W       = 16;
    localparam int PLANE_W     = 64;
    localparam int COEF_W      = 16;
    localparam int PLANE_COUNT = 6;

    // Plane arithmetic: products are Q10.22, the offset and margin are
    // brought to 22 fraction bits by a shift of 14.
    localparam int PROD_W     = 2 * COEF_W;
    localparam int SUM_W      = PROD_W + 3;
    localparam int FRAC_SHIFT = 14;

    // Configuration port.
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = PLANE_W;
    localparam int GRID_W_BITS = 9;
    localparam int MARGIN_W    = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INSIDE_MARGIN = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [GRID_W_BITS-1:0] GRID_WIDTH_RESET = 9'd2;
    localparam logic [MARGIN_W-1:0]    MARGIN_RESET     = 16'hFF00;
    localparam int                     MIN_GRID_WIDTH   = 2;

    // Default for the largest supported row length.
    localparam int DEF_MAX_GRID_WIDTH = 256;

    // One triangle of vertex indices.
    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic             last;
    } tgfc_tri_t;

    // Load request from the compute stage into the output buffer.
    typedef struct packed {
        logic load;
        logic first_ok;
        logic second_ok;
    } tgfc_emit_t;

    // Output buffer status seen by the pipeline.
    typedef struct packed {
        logic free;
        logic pend;
    } tgfc_obuf_stat_t;

endpackage

// ===== src/tgfc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data. A read of the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module tgfc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tgfc_plane_eval.sv =====
// ----------------------------------------------------------------------------
// Plane side test
// Registers the three coordinate products and the offset of one plane, then
// sums them and compares against the margin to flag the vertex as outside.
// ----------------------------------------------------------------------------
module tgfc_plane_eval (
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [tgfc_pkg::COORD_W-1:0] pos_x,
    input  logic signed [tgfc_pkg::COORD_W-1:0] pos_y,
    input  logic signed [tgfc_pkg::COORD_W-1:0] pos_z,
    input  logic [tgfc_pkg::PLANE_W-1:0]        plane,
    input  logic signed [tgfc_pkg::MARGIN_W-1:0] margin,
    output logic                                outside
);
    import tgfc_pkg::*;

    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic signed [PROD_W-1:0] prod_a_reg;
    logic signed [PROD_W-1:0] prod_b_reg;
    logic signed [PROD_W-1:0] prod_c_reg;
    logic signed [COEF_W-1:0] offset_reg;
    logic signed [SUM_W-1:0]  plane_val;
    logic signed [SUM_W-1:0]  limit;

    // Unpack the plane coefficients.
    assign coef_a = plane[COEF_W-1:0];
    assign coef_b = plane[2*COEF_W-1:COEF_W];
    assign coef_c = plane[3*COEF_W-1:2*COEF_W];
    assign coef_d = plane[4*COEF_W-1:3*COEF_W];

    // Product stage.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_a_reg <= coef_a * pos_x;
            prod_b_reg <= coef_b * pos_y;
            prod_c_reg <= coef_c * pos_z;
            offset_reg <= coef_d;
        end
    end

    // Sum and compare, all exact in Q13.22.
    assign plane_val = SUM_W'(prod_a_reg) + SUM_W'(prod_b_reg) + SUM_W'(prod_c_reg)
                       + (SUM_W'(offset_reg) <<< FRAC_SHIFT);
    assign limit   = SUM_W'(margin) <<< FRAC_SHIFT;
    assign outside = (plane_val > limit);

endmodule

// ===== src/tgfc_out_buf.sv =====
// ----------------------------------------------------------------------------
// Triangle output buffer
// Holds the triangle on the output port and a second pending triangle when a
// vertex keeps both halves of its quad.
// ----------------------------------------------------------------------------
module tgfc_out_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tgfc_pkg::tgfc_emit_t        emit,
    input  tgfc_pkg::tgfc_tri_t         tri_first,
    input  tgfc_pkg::tgfc_tri_t         tri_second,
    input  logic                        out_stall,
    output logic                        out_valid,
    output tgfc_pkg::tgfc_tri_t         out_tri,
    output tgfc_pkg::tgfc_obuf_stat_t   stat
);
    import tgfc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    logic      pend_reg;
    logic      pend_next;
    tgfc_tri_t out_reg;
    tgfc_tri_t out_next;
    tgfc_tri_t pend_tri_reg;
    tgfc_tri_t pend_tri_next;
    logic      take;
    logic      free;

    // The buffer can take a new vertex when it is empty or empties this cycle.
    assign take = valid_reg && !out_stall;
    assign free = !valid_reg || (take && !pend_reg);

    always_comb
    begin
        valid_next    = valid_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        pend_tri_next = pend_tri_reg;
        if (take && pend_reg)
        begin
            // Move the second triangle onto the port.
            out_next  = pend_tri_reg;
            pend_next = 1'b0;
        end
        else if (emit.load && free)
        begin
            valid_next    = emit.first_ok || emit.second_ok;
            pend_next     = emit.first_ok && emit.second_ok;
            out_next      = emit.first_ok ? tri_first : tri_second;
            pend_tri_next = tri_second;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    // Triangle payload.
    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        pend_tri_reg <= pend_tri_next;
    end

    assign out_valid = valid_reg;
    assign out_tri   = out_reg;
    assign stat.free = free;
    assign stat.pend = pend_reg;

endmodule

// ===== src/terrain_grid_frustum_culler_core.sv =====
// ----------------------------------------------------------------------------
// Terrain grid frustum culler
// Tests streamed terrain vertices against six planes and emits the kept
// triangles of each grid quad as vertex index triples.
// ----------------------------------------------------------------------------
// Vertices are taken one per clock cycle in raster order. Each request passes
// an input register, a product register (eighteen 16x16 multipliers, three
// per plane) and the sum, compare and triangle logic that loads the output
// register in that order. The output port moves one triangle per cycle while
// out_stall is low: a vertex that keeps both triangles of its quad holds the
// output for both and stalls the input while the second one waits, so the
// input takes one vertex per cycle as long as no vertex keeps both triangles
// and the output is not stalled. The previous row's inside flags live in a
// one-bit line store RAM of MAX_GRID_WIDTH entries; a fill count marks the
// entries written since reset, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module terrain_grid_frustum_culler_core #(
    parameter int MAX_GRID_WIDTH = tgfc_pkg::DEF_MAX_GRID_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [tgfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tgfc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [tgfc_pkg::COORD_W-1:0]   pos_x,
    input  logic signed [tgfc_pkg::COORD_W-1:0]   pos_y,
    input  logic signed [tgfc_pkg::COORD_W-1:0]   pos_z,
    input  logic                                  new_grid,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [tgfc_pkg::IDX_W-1:0]            corner_a,
    output logic [tgfc_pkg::IDX_W-1:0]            corner_b,
    output logic [tgfc_pkg::IDX_W-1:0]            corner_c,
    output logic                                  last_of_run
);
    import tgfc_pkg::*;

    localparam int COL_W  = $clog2(MAX_GRID_WIDTH);
    localparam int CNT_W  = $clog2(MAX_GRID_WIDTH + 1);
    localparam int GW_EXT = (CNT_W > GRID_W_BITS) ? CNT_W : GRID_W_BITS;

    // Configuration registers.
    logic [PLANE_W-1:0]        plane_reg [PLANE_COUNT];
    logic [GRID_W_BITS-1:0]    grid_width_reg;
    logic signed [MARGIN_W-1:0] margin_reg;

    // Row tracking at the input.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [IDX_W-1:0] vcount_reg;
    logic [IDX_W-1:0] vcount_next;
    logic             past_row_reg;
    logic             past_row_next;
    logic [COL_W-1:0] col_now;
    logic [IDX_W-1:0] vcount_now;
    logic             past_row_now;
    logic [GW_EXT-1:0] gw_ext;
    logic [GW_EXT-1:0] eff_w;
    logic              in_acc;

    // Input stage.
    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] s1_x_reg;
    logic signed [COORD_W-1:0] s1_y_reg;
    logic signed [COORD_W-1:0] s1_z_reg;
    logic [COL_W-1:0]          s1_col_reg;
    logic [IDX_W-1:0]          s1_v_reg;
    logic                      s1_emit_reg;
    logic                      s1_adv;

    // Product stage.
    logic             s2_valid_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [IDX_W-1:0] s2_v_reg;
    logic             s2_emit_reg;
    logic             bypass_reg;
    logic             bypass_flag_reg;
    logic             fill_ok_reg;
    logic             s2_adv;
    logic             s2_free;

    // Line store and neighbor flags.
    logic [CNT_W-1:0] fill_reg;
    logic             left_reg;
    logic             above_left_reg;
    logic             ram_q;
    logic [PLANE_COUNT-1:0] outside;
    logic             cur;
    logic             above;
    logic             keep_first;
    logic             keep_second;

    // Triangle assembly.
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] above_idx;
    logic [IDX_W-1:0] above_left_idx;
    tgfc_tri_t        tri_first;
    tgfc_tri_t        tri_second;
    tgfc_tri_t        out_tri;
    tgfc_emit_t       emit;
    tgfc_obuf_stat_t  ostat;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
            grid_width_reg <= GRID_WIDTH_RESET;
            margin_reg     <= MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PLANE_RIGHT:   plane_reg[REG_PLANE_RIGHT]  <= cfg_data;
                REG_PLANE_LEFT:    plane_reg[REG_PLANE_LEFT]   <= cfg_data;
                REG_PLANE_TOP:     plane_reg[REG_PLANE_TOP]    <= cfg_data;
                REG_PLANE_BOTTOM:  plane_reg[REG_PLANE_BOTTOM] <= cfg_data;
                REG_PLANE_FAR:     plane_reg[REG_PLANE_FAR]    <= cfg_data;
                REG_PLANE_NEAR:    plane_reg[REG_PLANE_NEAR]   <= cfg_data;
                REG_GRID_WIDTH:    grid_width_reg <= cfg_data[GRID_W_BITS-1:0];
                REG_INSIDE_MARGIN: margin_reg     <= cfg_data[MARGIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective row width, clamped to the supported range.
    assign gw_ext = GW_EXT'(grid_width_reg);
    always_comb
    begin
        eff_w = gw_ext;
        if (gw_ext < GW_EXT'(MIN_GRID_WIDTH))
        begin
            eff_w = GW_EXT'(MIN_GRID_WIDTH);
        end
        else if (gw_ext > GW_EXT'(MAX_GRID_WIDTH))
        begin
            eff_w = GW_EXT'(MAX_GRID_WIDTH);
        end
    end

    // Pipeline flow control.
    assign s2_adv   = s2_valid_reg && ostat.free;
    assign s2_free  = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign in_acc   = in_valid && !in_stall;

    // Row position of the incoming vertex; a new grid restarts the counters.
    always_comb
    begin
        col_now      = new_grid ? '0 : col_reg;
        vcount_now   = new_grid ? '0 : vcount_reg;
        past_row_now = new_grid ? 1'b0 : past_row_reg;
        vcount_next  = vcount_now + IDX_W'(1);
        if ((GW_EXT'(col_now) + GW_EXT'(1)) >= eff_w)
        begin
            col_next      = '0;
            past_row_next = 1'b1;
        end
        else
        begin
            col_next      = col_now + COL_W'(1);
            past_row_next = past_row_now;
        end
    end

    // Counters and pipeline control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            vcount_reg     <= '0;
            past_row_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            fill_reg       <= '0;
            left_reg       <= 1'b0;
            above_left_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                col_reg      <= col_next;
                vcount_reg   <= vcount_next;
                past_row_reg <= past_row_next;
            end
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            // Finished vertex updates the neighbor flags and the fill count.
            if (s2_adv)
            begin
                left_reg       <= cur;
                above_left_reg <= above;
                if (CNT_W'(s2_col_reg) == fill_reg)
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_x_reg    <= pos_x;
            s1_y_reg    <= pos_y;
            s1_z_reg    <= pos_z;
            s1_col_reg  <= col_now;
            s1_v_reg    <= vcount_now;
            s1_emit_reg <= past_row_now && (col_now != '0);
        end
        if (s1_adv)
        begin
            s2_col_reg      <= s1_col_reg;
            s2_v_reg        <= s1_v_reg;
            s2_emit_reg     <= s1_emit_reg;
            // Forward the flag written by the vertex leaving in this cycle.
            bypass_reg      <= s2_adv && (s2_col_reg == s1_col_reg);
            bypass_flag_reg <= cur;
            fill_ok_reg     <= CNT_W'(s1_col_reg) < fill_reg;
        end
    end

    // Previous row's inside flags.
    tgfc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s2_adv),
        .waddr (s2_col_reg),
        .wdata (cur),
        .re    (s1_adv),
        .raddr (s1_col_reg),
        .rdata (ram_q)
    );

    // One side test per plane.
    for (genvar g = 0; g < PLANE_COUNT; g++)
    begin : g_plane
        tgfc_plane_eval u_plane (
            .clk     (clk),
            .load    (s1_adv),
            .pos_x   (s1_x_reg),
            .pos_y   (s1_y_reg),
            .pos_z   (s1_z_reg),
            .plane   (plane_reg[g]),
            .margin  (margin_reg),
            .outside (outside[g])
        );
    end

    // Inside flags and triangle selection.
    assign cur         = ~|outside;
    assign above       = bypass_reg ? bypass_flag_reg : (fill_ok_reg && ram_q);
    assign keep_first  = s2_emit_reg && (left_reg || cur || above);
    assign keep_second = s2_emit_reg && (left_reg || above || above_left_reg);

    // Corner indices wrap modulo the index width.
    assign left_idx       = s2_v_reg - IDX_W'(1);
    assign above_idx      = s2_v_reg - IDX_W'(eff_w);
    assign above_left_idx = above_idx - IDX_W'(1);

    assign tri_first.a     = left_idx;
    assign tri_first.b     = s2_v_reg;
    assign tri_first.c     = above_idx;
    assign tri_first.last  = !keep_second;
    assign tri_second.a    = left_idx;
    assign tri_second.b    = above_idx;
    assign tri_second.c    = above_left_idx;
    assign tri_second.last = 1'b1;

    assign emit.load      = s2_adv;
    assign emit.first_ok  = keep_first;
    assign emit.second_ok = keep_second;

    tgfc_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .tri_first  (tri_first),
        .tri_second (tri_second),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_tri    (out_tri),
        .stat       (ostat)
    );

    assign corner_a    = out_tri.a;
    assign corner_b    = out_tri.b;
    assign corner_c    = out_tri.c;
    assign last_of_run = out_tri.last;

    // The fill count never passes the line store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_GRID_WIDTH))
        else $error("line store fill count beyond depth");

    // Rows are written in order, so every write extends or reuses the prefix.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_adv |-> (CNT_W'(s2_col_reg) <= fill_reg))
        else $error("line store write skips an entry");

    // A vertex never leaves the pipeline while a second triangle waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_adv |-> !ostat.pend)
        else $error("vertex retired over a pending triangle");

    // Every vertex that leaves the input stage lands in the product stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(s1_adv) |-> s2_valid_reg)
        else $error("product stage lost a vertex");

endmodule

// ===== bench/terrain_grid_frustum_culler_core_tb.sv =====
// ----------------------------------------------------------------------------
// Terrain grid frustum culler testbench
// Streams terrain vertices through the culler under a series of plane, width
// and margin settings, predicts the kept triangles of every grid quad and
// checks each emitted triangle in order. Both handshake sides idle and stall
// at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module terrain_grid_frustum_culler_core_tb;
    import tgfc_pkg::*;

    localparam int MAX_W          = DEF_MAX_GRID_WIDTH;
    localparam int REG_COUNT      = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int QUIET_LIMIT    = 3000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASES         = 15;
    localparam int PHASE_ITEMS    = 35;
    localparam int BIG_PHASE      = 7;
    localparam int PRESSURE_PHASE = 2 * PHASES / 3;
    localparam int REPORT_LINES   = 40;

    // Predicts the triangles that survive the frustum test and holds them
    // in emission order until the block delivers them.
    class kept_triangle_model;
        logic [PLANE_W-1:0]     planes [PLANE_COUNT];
        logic [GRID_W_BITS-1:0] grid_width;
        logic [MARGIN_W-1:0]    margin;
        bit                     row_flags [MAX_W];
        bit                     above_left;
        bit                     left;
        int unsigned            column;
        logic [IDX_W-1:0]       vertex_index;
        bit                     past_first_row;
        tgfc_tri_t              kept_triangles [$];
        int                     mismatches;
        int                     checked;

        function new();
            foreach (planes[i]) planes[i] = '0;
            foreach (row_flags[i]) row_flags[i] = 1'b0;
            grid_width     = GRID_WIDTH_RESET;
            margin         = MARGIN_RESET;
            above_left     = 1'b0;
            left           = 1'b0;
            column         = 0;
            vertex_index   = '0;
            past_first_row = 1'b0;
            mismatches     = 0;
            checked        = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] index,
                              input logic [CFG_DATA_W-1:0] data);
            if (index == REG_GRID_WIDTH)
                grid_width = data[GRID_W_BITS-1:0];
            else if (index == REG_INSIDE_MARGIN)
                margin = data[MARGIN_W-1:0];
            else
                planes[index] = data;
        endfunction

        // Row length after clamping the register to the supported range.
        function int unsigned eff_width();
            if (grid_width < MIN_GRID_WIDTH)
                return MIN_GRID_WIDTH;
            if (grid_width > MAX_W)
                return MAX_W;
            return grid_width;
        endfunction

        function int pending();
            return kept_triangles.size();
        endfunction

        // A point is inside when no plane value exceeds the margin. The
        // products are Q10.22, so the offset and margin are scaled by 2^14.
        function bit point_inside(input logic [COORD_W-1:0] x, y, z);
            longint scale;
            longint limit;
            longint s;
            scale = longint'(1) << FRAC_SHIFT;
            limit = longint'($signed(margin)) * scale;
            foreach (planes[i])
            begin
                s = longint'($signed(planes[i][15:0])) * longint'($signed(x))
                  + longint'($signed(planes[i][31:16])) * longint'($signed(y))
                  + longint'($signed(planes[i][47:32])) * longint'($signed(z))
                  + longint'($signed(planes[i][63:48])) * scale;
                if (s > limit)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // Walks one accepted vertex through the grid and queues the
        // triangles of the quad that it closes.
        function void note_vertex(input logic [COORD_W-1:0] x, y, z,
                                  input logic restart);
            int unsigned      w;
            int unsigned      col;
            bit               cur;
            bit               above;
            bit               keep_first;
            bit               keep_second;
            logic [IDX_W-1:0] v;
            logic [IDX_W-1:0] left_i;
            logic [IDX_W-1:0] above_i;
            tgfc_tri_t        t;
            w = eff_width();
            if (restart)
            begin
                column         = 0;
                vertex_index   = '0;
                past_first_row = 1'b0;
            end
            if (column >= MAX_W)
                column = 0;
            col   = column;
            v     = vertex_index;
            cur   = point_inside(x, y, z);
            above = row_flags[col];

            if (past_first_row && col >= 1)
            begin
                left_i      = v - 16'd1;
                above_i     = v - IDX_W'(w);
                keep_first  = left || cur || above;
                keep_second = left || above || above_left;
                if (keep_first)
                begin
                    t.a    = left_i;
                    t.b    = v;
                    t.c    = above_i;
                    t.last = !keep_second;
                    kept_triangles.push_back(t);
                end
                if (keep_second)
                begin
                    t.a    = left_i;
                    t.b    = above_i;
                    t.c    = above_i - 16'd1;
                    t.last = 1'b1;
                    kept_triangles.push_back(t);
                end
            end

            above_left     = above;
            left           = cur;
            row_flags[col] = cur;
            vertex_index   = vertex_index + 16'd1;
            // A row also ends when a narrowed width is already passed.
            if (col + 1 >= w)
            begin
                column         = 0;
                past_first_row = 1'b1;
            end
            else
            begin
                column = col + 1;
            end
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= REPORT_LINES)
                $display("mismatch at triangle %0d: %s", checked, what);
        endtask

        task compare_field(input string name, input logic [IDX_W-1:0] got,
                           input logic [IDX_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        task check_triangle(input tgfc_tri_t got);
            tgfc_tri_t want;
            checked++;
            if (kept_triangles.size() == 0)
            begin
                report_mismatch($sformatf("unexpected triangle %0d %0d %0d, last %0b",
                                          got.a, got.b, got.c, got.last));
                return;
            end
            want = kept_triangles.pop_front();
            compare_field("corner_a", got.a, want.a);
            compare_field("corner_b", got.b, want.b);
            compare_field("corner_c", got.c, want.c);
            compare_field("last_of_run", IDX_W'(got.last), IDX_W'(want.last));
        endtask
    endclass

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic signed [COORD_W-1:0]   pos_x     = '0;
    logic signed [COORD_W-1:0]   pos_y     = '0;
    logic signed [COORD_W-1:0]   pos_z     = '0;
    logic                        new_grid  = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [IDX_W-1:0]            corner_a;
    logic [IDX_W-1:0]            corner_b;
    logic [IDX_W-1:0]            corner_c;
    logic                        last_of_run;

    int                          send_idle_pct   = 25;
    int                          recv_stall_pct  = 52;
    bit                          holdoff_request = 1'b0;
    int                          holdoff_left    = 0;
    int                          quiet_cycles    = 0;
    logic [CFG_DATA_W-1:0]       reg_plan [REG_COUNT];
    kept_triangle_model          tri_model = new();

    terrain_grid_frustum_culler_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .new_grid    (new_grid),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .corner_a    (corner_a),
        .corner_b    (corner_b),
        .corner_c    (corner_c),
        .last_of_run (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side: check each accepted triangle and pick the next stall,
    // with one long hold-off when the stimulus asks for it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tri_model.check_triangle(tgfc_tri_t'({corner_a, corner_b, corner_c, last_of_run}));
        if (holdoff_left != 0)
        begin
            holdoff_left = holdoff_left - 1;
            out_stall <= 1'b1;
        end
        else if (holdoff_request)
        begin
            holdoff_request = 1'b0;
            holdoff_left    = HOLDOFF_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: give up when neither side moves a request for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // Offer one vertex, holding it until the block takes it.
    task automatic send_vertex(input logic [COORD_W-1:0] x, y, z, input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= x;
        pos_y    <= y;
        pos_z    <= z;
        new_grid <= restart;
        do @(posedge clk); while (in_stall);
        tri_model.note_vertex(x, y, z, restart);
    endtask

    // Wait until every expected triangle is out and the pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (tri_model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [REG_COUNT-1:0] mask);
        for (int i = 0; i < REG_COUNT; i++)
        begin
            if (mask[i])
            begin
                cfg_we    <= 1'b1;
                cfg_index <= CFG_IDX_W'(i);
                cfg_data  <= reg_plan[i];
                @(posedge clk);
                tri_model.set_reg(CFG_IDX_W'(i), reg_plan[i]);
            end
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned          kind;
        int unsigned          axis;
        int unsigned          w;
        int unsigned          n;
        int unsigned          sent;
        int                   m;
        logic [MARGIN_W-1:0]  d;
        logic [REG_COUNT-1:0] mask;
        logic                 restart;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: all planes zero, so every vertex is outside. The
        // stream starts without a new-grid mark.
        send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h8000, 16'h7FFF, 16'h0000, 1'b0);

        // A 3x3 grid against extreme plane coefficients with a mix of
        // inside and outside corners.
        settle();
        reg_plan[REG_PLANE_RIGHT]   = 64'h0000_0000_0000_4000;
        reg_plan[REG_PLANE_LEFT]    = 64'h8000_7FFF_8000_7FFF;
        reg_plan[REG_PLANE_TOP]     = '1;
        reg_plan[REG_PLANE_BOTTOM]  = '0;
        reg_plan[REG_PLANE_FAR]     = '0;
        reg_plan[REG_PLANE_NEAR]    = '0;
        reg_plan[REG_GRID_WIDTH]    = 64'd3;
        reg_plan[REG_INSIDE_MARGIN] = 64'd0;
        write_regs('1);
        send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_vertex(16'h7FFF, 16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h0000, 16'h8000, 16'h0000, 1'b0);
        send_vertex(16'h0000, 16'h7FFF, 16'h8000, 1'b0);
        send_vertex(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h8000, 16'h0000, 16'h0000, 1'b0);

        // Width below the minimum clamps to two; rows simply continue.
        settle();
        reg_plan[REG_GRID_WIDTH] = 64'd0;
        write_regs(REG_COUNT'(1) << REG_GRID_WIDTH);
        send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 16'h0000, 1'b0);
        send_vertex(16'h0000, 16'h0000, 16'h7FFF, 1'b0);

        // Widest register value mid-row with the largest margin: the above
        // indices wrap below zero.
        settle();
        reg_plan[REG_GRID_WIDTH]    = 64'd511;
        reg_plan[REG_INSIDE_MARGIN] = 64'h7FFF;
        write_regs((REG_COUNT'(1) << REG_GRID_WIDTH) | (REG_COUNT'(1) << REG_INSIDE_MARGIN));
        send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h0000, 16'h8000, 1'b0);

        // Width one with the smallest margin: the current column is already
        // past the row end, then a fresh grid starts.
        settle();
        reg_plan[REG_GRID_WIDTH]    = 64'd1;
        reg_plan[REG_INSIDE_MARGIN] = 64'h8000;
        write_regs((REG_COUNT'(1) << REG_GRID_WIDTH) | (REG_COUNT'(1) << REG_INSIDE_MARGIN));
        send_vertex(16'h8000, 16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1);
        send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);

        // Random phases: new settings each time, mostly whole grids.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < PHASES / 3)
            begin
                send_idle_pct  = 25;
                recv_stall_pct = 52;
            end
            else if (phase < PRESSURE_PHASE)
            begin
                send_idle_pct  = 52;
                recv_stall_pct = 25;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            settle();

            case ($urandom_range(0, 9))
                0:       m = -32768;
                1:       m = 32767;
                2:       m = -256;
                default: m = int'($urandom_range(0, 65535)) - 32768;
            endcase
            // Narrow registers get junk above their width.
            reg_plan[REG_INSIDE_MARGIN]        = {$urandom(), $urandom()};
            reg_plan[REG_INSIDE_MARGIN][15:0]  = MARGIN_W'(m);
            reg_plan[REG_GRID_WIDTH]           = {$urandom(), $urandom()};
            if (phase == BIG_PHASE)
                reg_plan[REG_GRID_WIDTH][8:0] = GRID_W_BITS'($urandom_range(256, 511));
            else
            begin
                case ($urandom_range(0, 9))
                    0:       reg_plan[REG_GRID_WIDTH][8:0] = GRID_W_BITS'($urandom_range(0, 1));
                    1:       reg_plan[REG_GRID_WIDTH][8:0] = GRID_W_BITS'($urandom_range(9, 40));
                    default: reg_plan[REG_GRID_WIDTH][8:0] = GRID_W_BITS'($urandom_range(2, 8));
                endcase
            end
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 5)
                begin
                    // Open plane: no normal and an offset at or below the margin.
                    d = MARGIN_W'(m - int'($urandom_range(0, m + 32768)));
                    reg_plan[i] = {d, 48'h0};
                end
                else if (kind < 9)
                begin
                    // One axis against a random offset splits the points.
                    axis = $urandom_range(0, 2);
                    reg_plan[i] = {16'($urandom()), 48'h0};
                    reg_plan[i][16 * axis +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
                end
                else
                begin
                    reg_plan[i] = {$urandom(), $urandom()};
                end
            end
            mask = (phase == 0) ? '1 : (REG_COUNT'($urandom_range(0, 255))
                                        | (REG_COUNT'(1) << REG_GRID_WIDTH));
            write_regs(mask);
            if (phase == PRESSURE_PHASE)
                holdoff_request = 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                w = tri_model.eff_width();
                if (w > 40)
                    n = w + 8;
                else if (w > 8)
                    n = 2 * w;
                else
                    n = w * $urandom_range(2, 5);
                // Mostly whole grids; some cut short, unmarked or restarted.
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    n = $urandom_range(1, n);
                for (int k = 0; k < n; k++)
                begin
                    restart = (k == 0) && (kind != 1);
                    if (kind == 2 && $urandom_range(0, 15) == 0)
                        restart = 1'b1;
                    send_vertex(rand_coord(), rand_coord(), rand_coord(), restart);
                end
                sent += n;
            end
        end

        settle();
        if (tri_model.mismatches == 0 && tri_model.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
